// ===== design/nhst_pkg.sv =====
// Shared types, constants, saturating and rounding helpers for the neo-Hookean stress block.
`default_nettype none
package nhst_pkg;

  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_LAME_LAMBDA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR_MOD   = 1'd1;

  localparam logic [CFG_W-1:0] LAME_RST  = 31'd65536;
  localparam logic [CFG_W-1:0] SHEAR_RST = 31'd65536;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam int B_ROW [0:5] = '{0, 1, 2, 0, 1, 0};
  localparam int B_COL [0:5] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic signed [31:0] f11;
    logic signed [31:0] f12;
    logic signed [31:0] f13;
    logic signed [31:0] f21;
    logic signed [31:0] f22;
    logic signed [31:0] f23;
    logic signed [31:0] f31;
    logic signed [31:0] f32;
    logic signed [31:0] f33;
    logic signed [31:0] det_j;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] s11;
    logic signed [31:0] s22;
    logic signed [31:0] s33;
    logic signed [31:0] s12;
    logic signed [31:0] s23;
    logic signed [31:0] s13;
    logic signed [31:0] tangent_diag;
    logic signed [31:0] tangent_shear;
    logic               j_invalid;
  } out_beat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      return s[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage
`default_nettype wire

// ===== design/nhst_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat per handshake.
`default_nettype none
interface nhst_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/nhst_ln.sv =====
// Pipelined natural logarithm of a positive fixed-point value by repeated squaring.
`default_nettype none
module nhst_ln #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [30:0]        x,
  output logic signed [31:0]      ln_q
);
  import nhst_pkg::*;

  localparam int LW = FRAC_BITS + 7;
  localparam int PW = LW + 31;

  typedef struct packed {
    logic [4:0]           p;
    logic [30:0]          m;
    logic [FRAC_BITS-1:0] frac;
  } ln_st_t;

  ln_st_t st_r [0:FRAC_BITS];
  ln_st_t st_nxt [1:FRAC_BITS];

  logic [4:0]            p0;
  logic [30:0]           m0;
  logic signed [6:0]     pd;
  logic signed [LW-1:0]  log2v;
  logic signed [PW-1:0]  prod_nxt;
  logic signed [PW-1:0]  prod_r;
  logic [PW-1:0]         mag;
  logic [PW-1:0]         rnd;
  logic signed [31:0]    ln_nxt;
  logic signed [31:0]    ln_r;

  always_comb begin
    p0 = '0;
    for (int i = 0; i < 31; i++) begin
      if (x[i]) begin
        p0 = 5'(i);
      end
    end
    m0 = x << (5'd30 - p0);
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] t;
    always_comb begin
      sq = 62'(st_r[k-1].m) * 62'(st_r[k-1].m);
      t = sq[61:30];
      st_nxt[k].p = st_r[k-1].p;
      st_nxt[k].frac = {st_r[k-1].frac[FRAC_BITS-2:0], t[31]};
      st_nxt[k].m = t[31] ? t[31:1] : t[30:0];
    end
  end

  always_comb begin
    pd = $signed(7'(st_r[FRAC_BITS].p)) - 7'sd1 * 7'(FRAC_BITS);
    log2v = $signed({pd, st_r[FRAC_BITS].frac});
    prod_nxt = log2v * $signed({1'b0, LN2_Q30});
    mag = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
    rnd = (mag + (PW'(1) << 29)) >> 30;
    if (prod_r[PW-1]) begin
      ln_nxt = (rnd > PW'(64'h8000_0000)) ? 32'sh80000000 : 32'(-rnd);
    end else begin
      ln_nxt = (rnd > PW'(64'h7fff_ffff)) ? 32'sh7fffffff : 32'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= '{p: p0, m: m0, frac: '0};
      for (int k = 1; k <= FRAC_BITS; k++) begin
        st_r[k] <= st_nxt[k];
      end
      prod_r <= prod_nxt;
      ln_r <= ln_nxt;
    end
  end

  assign ln_q = ln_r;

endmodule
`default_nettype wire

// ===== design/nhst_div.sv =====
// Pipelined rounding divider, one quotient bit per stage, saturated to 32 bits.
`default_nettype none
module nhst_div (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [63:0] num,
  input  wire logic [30:0]        den,
  output logic signed [31:0]      q
);
  import nhst_pkg::*;

  localparam int STEPS = 33;

  typedef struct packed {
    logic [30:0] rem;
    logic [32:0] low;
    logic [32:0] quo;
    logic [30:0] den;
    logic        ovf;
    logic        neg;
  } div_st_t;

  logic [63:0]        mag_r;
  logic [30:0]        den_r;
  logic               neg_r;
  div_st_t            st_r [0:STEPS];
  div_st_t            st_nxt [1:STEPS];
  logic signed [31:0] q_nxt;
  logic signed [31:0] q_r;

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [31:0] t;
    logic        ge;
    always_comb begin
      t = {st_r[k-1].rem, st_r[k-1].low[32]};
      ge = (t >= {1'b0, st_r[k-1].den});
      st_nxt[k] = st_r[k-1];
      st_nxt[k].rem = ge ? 31'(t - {1'b0, st_r[k-1].den}) : t[30:0];
      st_nxt[k].low = {st_r[k-1].low[31:0], 1'b0};
      st_nxt[k].quo = {st_r[k-1].quo[31:0], ge};
    end
  end

  always_comb begin
    if (st_r[STEPS].neg) begin
      if (st_r[STEPS].ovf || (st_r[STEPS].quo > 33'h0_8000_0000)) begin
        q_nxt = 32'sh80000000;
      end else begin
        q_nxt = 32'(-st_r[STEPS].quo);
      end
    end else begin
      if (st_r[STEPS].ovf || (st_r[STEPS].quo > 33'h0_7fff_ffff)) begin
        q_nxt = 32'sh7fffffff;
      end else begin
        q_nxt = st_r[STEPS].quo[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= (num[63] ? 64'(-num) : 64'(num)) + {34'd0, den[30:1]};
      den_r <= den;
      neg_r <= num[63];
      st_r[0] <= '{rem: mag_r[63:33], low: mag_r[32:0], quo: '0, den: den_r,
                   ovf: (mag_r[63:33] >= den_r), neg: neg_r};
      for (int k = 1; k <= STEPS; k++) begin
        st_r[k] <= st_nxt[k];
      end
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

// ===== design/neo_hookean_stress_tangent_top.sv =====
// Top level: neo-Hookean Cauchy stress and tangent moduli for one integration point per beat.
//
//  channel | direction | payload                               | handshake
//  in_ch   | sink      | f11..f33, det_j                       | valid/ready
//  out_ch  | source    | s11..s13, tangent_diag/shear, j_invalid | valid/ready
//  cfg_*   | write     | lame_lambda (0), shear_mod (1)        | cfg_we
//
// One beat is accepted per cycle unless a result waits unaccepted at the output.
// The pipeline depth comes from the FRAC_BITS squaring stages of the logarithm and the
// 33 one-bit stages of the six dividers. Reset clears the valid bits and loads the
// register defaults. While a result waits unaccepted, every stage holds in place.
`default_nettype none
module neo_hookean_stress_tangent_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  nhst_stream_if.sink                          in_ch,
  nhst_stream_if.source                        out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [nhst_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [nhst_pkg::CFG_W-1:0]      cfg_wdata
);
  import nhst_pkg::*;

  localparam int LN_LAT  = FRAC_BITS + 3;
  localparam int BD      = LN_LAT - 3;
  localparam int L2      = LN_LAT + 2;
  localparam int DIV_LAT = 36;
  localparam int S_DIV   = L2 + DIV_LAT;
  localparam logic signed [32:0] ONE_FX = 33'sd1 <<< FRAC_BITS;

  logic [CFG_W-1:0]   lam_r;
  logic [CFG_W-1:0]   mu_r;
  logic               adv;

  logic               vld_r [0:S_DIV];
  logic               inv_r [0:S_DIV];
  logic signed [31:0] f0_r [0:8];
  logic [30:0]        jd_r [0:L2];

  logic signed [63:0] bp_nxt [0:5][0:2];
  logic signed [63:0] bp_r [0:5][0:2];
  logic signed [63:0] bs1_r [0:5];
  logic signed [63:0] bp2_r [0:5];
  logic signed [63:0] bs2_r [0:5];
  logic signed [32:0] bm_nxt [0:5];
  logic signed [32:0] bm_r [0:BD-1][0:5];

  logic signed [31:0] lnj;
  logic signed [64:0] pm_full [0:5];
  logic signed [63:0] pm_r [0:5];
  logic signed [63:0] lamln_nxt;
  logic signed [63:0] lamln_r;
  logic signed [63:0] num_r [0:5];
  logic signed [63:0] mup_r;
  logic signed [31:0] td_r [0:DIV_LAT-1];
  logic signed [31:0] ts_r [0:DIV_LAT-1];
  logic signed [31:0] dq [0:5];

  logic               out_valid_r;
  out_beat_t          out_data_r;
  out_beat_t          out_data_nxt;

  assign adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lam_r <= LAME_RST;
      mu_r <= SHEAR_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LAME_LAMBDA: lam_r <= cfg_wdata;
        REG_SHEAR_MOD:   mu_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  nhst_ln #(.FRAC_BITS(FRAC_BITS)) u_ln (
    .clk  (clk),
    .en   (adv),
    .x    (jd_r[0]),
    .ln_q (lnj)
  );

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      for (int j = 0; j < 3; j++) begin
        bp_nxt[k][j] = f0_r[B_ROW[k] * 3 + j] * f0_r[B_COL[k] * 3 + j];
      end
      bm_nxt[k] = 33'(sat32(rnd_shift(bs2_r[k], FRAC_BITS)));
      if (B_ROW[k] == B_COL[k]) begin
        bm_nxt[k] = bm_nxt[k] - ONE_FX;
      end
      pm_full[k] = $signed({1'b0, mu_r}) * bm_r[BD-1][k];
    end
    lamln_nxt = $signed({1'b0, lam_r}) * lnj;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_r[0] <= in_ch.data.f11;
      f0_r[1] <= in_ch.data.f12;
      f0_r[2] <= in_ch.data.f13;
      f0_r[3] <= in_ch.data.f21;
      f0_r[4] <= in_ch.data.f22;
      f0_r[5] <= in_ch.data.f23;
      f0_r[6] <= in_ch.data.f31;
      f0_r[7] <= in_ch.data.f32;
      f0_r[8] <= in_ch.data.f33;
      jd_r[0] <= in_ch.data.det_j[30:0];
      inv_r[0] <= in_ch.data.det_j[31] || (in_ch.data.det_j == 32'sd0);
      for (int i = 1; i <= L2; i++) begin
        jd_r[i] <= jd_r[i-1];
      end
      for (int i = 1; i <= S_DIV; i++) begin
        inv_r[i] <= inv_r[i-1];
      end
      for (int k = 0; k < 6; k++) begin
        for (int j = 0; j < 3; j++) begin
          bp_r[k][j] <= bp_nxt[k][j];
        end
        bs1_r[k] <= sat_add64(bp_r[k][0], bp_r[k][1]);
        bp2_r[k] <= bp_r[k][2];
        bs2_r[k] <= sat_add64(bs1_r[k], bp2_r[k]);
        bm_r[0][k] <= bm_nxt[k];
        for (int i = 1; i < BD; i++) begin
          bm_r[i][k] <= bm_r[i-1][k];
        end
        pm_r[k] <= pm_full[k][63:0];
        num_r[k] <= (B_ROW[k] == B_COL[k]) ? sat_add64(pm_r[k], lamln_r) : pm_r[k];
      end
      lamln_r <= lamln_nxt;
      mup_r <= $signed(64'(mu_r)) - rnd_shift(lamln_r, FRAC_BITS);
      ts_r[0] <= sat32(mup_r);
      td_r[0] <= sat32($signed(64'(lam_r)) + (mup_r <<< 1));
      for (int i = 1; i < DIV_LAT; i++) begin
        ts_r[i] <= ts_r[i-1];
        td_r[i] <= td_r[i-1];
      end
      out_data_r <= out_data_nxt;
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_div
    nhst_div u_div (
      .clk (clk),
      .en  (adv),
      .num (num_r[k]),
      .den (jd_r[L2]),
      .q   (dq[k])
    );
  end

  always_comb begin
    if (inv_r[S_DIV]) begin
      out_data_nxt = '0;
      out_data_nxt.j_invalid = 1'b1;
    end else begin
      out_data_nxt.s11 = dq[0];
      out_data_nxt.s22 = dq[1];
      out_data_nxt.s33 = dq[2];
      out_data_nxt.s12 = dq[3];
      out_data_nxt.s23 = dq[4];
      out_data_nxt.s13 = dq[5];
      out_data_nxt.tangent_diag = td_r[DIV_LAT-1];
      out_data_nxt.tangent_shear = ts_r[DIV_LAT-1];
      out_data_nxt.j_invalid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= S_DIV; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i <= S_DIV; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[S_DIV];
    end
  end

  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input side stalled without a held result");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.j_invalid) |->
      (out_ch.data.s11 == 32'sd0 && out_ch.data.tangent_diag == 32'sd0 &&
       out_ch.data.tangent_shear == 32'sd0))
    else $error("invalid determinant result carries nonzero fields");

  a_valid_travels: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[0]) |=> vld_r[1])
    else $error("valid bit lost between pipeline stages");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

// ===== tb/nhst_stress_checker.sv =====
// Checker that predicts each stress and tangent result and compares it with the output channel.
`timescale 1ns / 1ps
`default_nettype none
module nhst_stress_checker #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire nhst_pkg::in_beat_t             in_data,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire nhst_pkg::out_beat_t            out_data,
  input  wire logic                           cfg_we,
  input  wire logic [nhst_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [nhst_pkg::CFG_W-1:0]     cfg_wdata,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  checked
);
  import nhst_pkg::*;

  localparam longint LN2_MUL = 744261118;

  logic [CFG_W-1:0] lambda_q;
  logic [CFG_W-1:0] mu_q;
  out_beat_t        pending_results[$];

  string field_names[0:7] = '{"s11", "s22", "s33", "s12", "s23", "s13",
                              "tangent_diag", "tangent_shear"};

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint add_clip64(input longint a, input longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
    return s[63:0];
  endfunction

  function automatic longint unsigned magnitude(input longint v);
    longint unsigned u;
    u = v;
    return v < 0 ? -u : u;
  endfunction

  function automatic longint round_pow2(input longint v, input int sh);
    longint unsigned mg;
    mg = (magnitude(v) + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(mg) : longint'(mg);
  endfunction

  function automatic longint natural_log(input longint unsigned x);
    int                p;
    longint unsigned   m;
    longint            frac;
    longint            log2v;
    p = 0;
    frac = 0;
    for (int i = 0; i < 31; i++) begin
      if (x[i]) p = i;
    end
    m = x << (30 - p);
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    log2v = longint'(p - FRAC_BITS) * (64'sd1 << FRAC_BITS) + frac;
    return clip32(round_pow2(log2v * LN2_MUL, 30));
  endfunction

  function automatic longint divide_round(input longint num, input longint den);
    longint unsigned q;
    q = (magnitude(num) + longint'(den >>> 1)) / longint'(den);
    if (num < 0) return (q > (64'd1 << 31)) ? -64'sd2147483648 : -longint'(q);
    return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic out_beat_t material_response(input in_beat_t x);
    out_beat_t r;
    longint    f[3][3];
    longint    jdet, lam, mu, lnj, lamln, sum, bij, num, mup;
    logic [31:0] s[6];
    r = '0;
    jdet = x.det_j;
    if (jdet <= 0) begin
      r.j_invalid = 1'b1;
      return r;
    end
    f[0][0] = x.f11; f[0][1] = x.f12; f[0][2] = x.f13;
    f[1][0] = x.f21; f[1][1] = x.f22; f[1][2] = x.f23;
    f[2][0] = x.f31; f[2][1] = x.f32; f[2][2] = x.f33;
    lam = longint'(lambda_q);
    mu = longint'(mu_q);
    lnj = natural_log(jdet);
    lamln = lam * lnj;
    for (int k = 0; k < 6; k++) begin
      sum = f[B_ROW[k]][0] * f[B_COL[k]][0];
      sum = add_clip64(sum, f[B_ROW[k]][1] * f[B_COL[k]][1]);
      sum = add_clip64(sum, f[B_ROW[k]][2] * f[B_COL[k]][2]);
      bij = clip32(round_pow2(sum, FRAC_BITS));
      if (B_ROW[k] == B_COL[k]) bij = bij - (64'sd1 << FRAC_BITS);
      num = mu * bij;
      if (B_ROW[k] == B_COL[k]) num = add_clip64(num, lamln);
      s[k] = 32'(divide_round(num, jdet));
    end
    mup = mu - round_pow2(lamln, FRAC_BITS);
    r.s11 = s[0]; r.s22 = s[1]; r.s33 = s[2];
    r.s12 = s[3]; r.s23 = s[4]; r.s13 = s[5];
    r.tangent_diag = 32'(clip32(lam + 2 * mup));
    r.tangent_shear = 32'(clip32(mup));
    r.j_invalid = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t exp_r;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      lambda_q <= LAME_RST;
      mu_q <= SHEAR_RST;
      fail_count <= 0;
      checked <= 0;
      pending <= 0;
      pending_results.delete();
    end else begin
      if (in_valid && in_ready) pending_results.push_back(material_response(in_data));
      if (cfg_we) begin
        if (cfg_idx == REG_LAME_LAMBDA) lambda_q <= cfg_wdata;
        else if (cfg_idx == REG_SHEAR_MOD) mu_q <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        checked <= checked + 1;
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $time, out_data);
          errs++;
        end else begin
          exp_r = pending_results.pop_front();
          for (int k = 0; k < 8; k++) begin
            if (exp_r[256-32*k -: 32] !== out_data[256-32*k -: 32]) begin
              $display("%0t: %s expected %0d actual %0d", $time, field_names[k],
                       $signed(exp_r[256-32*k -: 32]), $signed(out_data[256-32*k -: 32]));
              errs++;
            end
          end
          if (exp_r.j_invalid !== out_data.j_invalid) begin
            $display("%0t: j_invalid expected %b actual %b", $time, exp_r.j_invalid,
                     out_data.j_invalid);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= pending_results.size();
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench top: stimulus, configuration phases and verdict for the neo-Hookean stress block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import nhst_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY   = FRAC_BITS + 42;
  localparam int MAX_CYCLES = 400000;
  localparam logic [CFG_W-1:0] CFG_MAX = 31'h7fffffff;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  int               fail_count, pending, checked, sent;
  int               cycles = 0;
  int               stall_mode = 0;
  int               stall_left = 0;

  nhst_stream_if #(.payload_t(in_beat_t))  in_ch();
  nhst_stream_if #(.payload_t(out_beat_t)) out_ch();

  neo_hookean_stress_tangent_top #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  nhst_stress_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver switches between always ready, random stalls and mostly stalled.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_beat(input in_beat_t b);
    logic taken;
    in_ch.data <= b;
    in_ch.valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
    sent++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic set_moduli(input logic [CFG_W-1:0] lam, input logic [CFG_W-1:0] mu);
    cfg_we <= 1'b1;
    cfg_idx <= REG_LAME_LAMBDA;
    cfg_wdata <= lam;
    @(posedge clk);
    cfg_idx <= REG_SHEAR_MOD;
    cfg_wdata <= mu;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] near_one(input int spread);
    return 32'sd65536 + $signed($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic in_beat_t random_point();
    in_beat_t b;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      b.f11 = near_one(30000); b.f22 = near_one(30000); b.f33 = near_one(30000);
      b.f12 = $signed($urandom_range(0, 40000)) - 20000;
      b.f13 = $signed($urandom_range(0, 40000)) - 20000;
      b.f21 = $signed($urandom_range(0, 40000)) - 20000;
      b.f23 = $signed($urandom_range(0, 40000)) - 20000;
      b.f31 = $signed($urandom_range(0, 40000)) - 20000;
      b.f32 = $signed($urandom_range(0, 40000)) - 20000;
      b.det_j = $urandom_range(8192, 400000);
    end else if (sel < 75) begin
      b = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
      b.det_j = 32'(-$signed({1'b0, $urandom_range(0, 32'h7fffffff)}));
    end else begin
      b = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
      if (sel < 88) b.det_j = $urandom_range(1, 32'h7fffffff);
    end
    return b;
  endfunction

  task automatic run_random(input int count);
    int burst;
    int done;
    done = 0;
    while (done < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && done < count; i++) begin
        send_beat(random_point());
        done++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  task automatic run_directed;
    in_beat_t b;
    logic signed [31:0] dets[7];
    dets = '{32'sd65536, 32'sd1, 32'sh7fffffff, 32'sd0, -32'sd65536, 32'sh80000000, 32'sd32768};
    foreach (dets[i]) begin
      b = '0;
      b.f11 = 32'sd65536; b.f22 = 32'sd65536; b.f33 = 32'sd65536;
      b.det_j = dets[i];
      send_beat(b);
    end
    b = {10{32'sh7fffffff}};
    b.det_j = 32'sd65536;
    send_beat(b);
    b = {10{32'sh80000000}};
    b.det_j = 32'sd1;
    send_beat(b);
    b = '0;
    b.det_j = 32'sd1;
    send_beat(b);
    b = {10{32'sh80000000}};
    b.f12 = 32'sh7fffffff; b.f22 = 32'sh7fffffff; b.f32 = 32'sh7fffffff;
    b.det_j = 32'sh7fffffff;
    send_beat(b);
    b = '0;
    b.f11 = 32'sd131072; b.f22 = 32'sd32768; b.f33 = 32'sd65536; b.f12 = -32'sd16384;
    b.det_j = 32'sd65536;
    send_beat(b);
    b = {10{32'shffffffff}};
    b.det_j = 32'sd100;
    send_beat(b);
    idle_cycles(1);
  endtask

  initial begin
    rst_n = 1'b0;
    sent = 0;
    cfg_we = 1'b0;
    cfg_idx = REG_LAME_LAMBDA;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(240);
    drain();
    set_moduli('0, '0);
    run_directed();
    run_random(180);
    drain();
    set_moduli(CFG_MAX, CFG_MAX);
    run_directed();
    run_random(180);
    drain();
    set_moduli('0, CFG_MAX);
    run_random(180);
    drain();
    set_moduli(CFG_MAX, '0);
    run_random(180);
    drain();
    set_moduli(31'($urandom_range(1, 32'h7fffffff)), 31'($urandom_range(1, 32'h7fffffff)));
    run_random(150);
    drain();
    set_moduli(31'($urandom_range(0, 32'h00100000)), 31'($urandom_range(0, 32'h00100000)));
    run_random(150);
    drain();
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d deformation beats over seven modulus settings, extremes included.",
             sent);
    $display("Checked %0d stress and tangent results, %0d mismatches.", checked, fail_count);
    if (fail_count == 0 && checked == sent) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
design/nhst_pkg.sv
design/nhst_stream_if.sv
design/nhst_ln.sv
design/nhst_div.sv
design/neo_hookean_stress_tangent_top.sv
tb/nhst_stress_checker.sv
tb/tb.sv
